// File: rtl/eul_pkg.sv
// ----------------------------------------------------------------------------
// eul_pkg
// Shared types, constants and helpers of the execute-unit latency scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package eul_pkg;

    // queue geometry
    localparam int INFLIGHT_DEPTH      = 8;
    localparam int WAITING_DEPTH       = 8;
    localparam int NUM_BLOCKING_GROUPS = 4;
    localparam int IF_IDX_W = $clog2(INFLIGHT_DEPTH);
    localparam int IF_CNT_W = $clog2(INFLIGHT_DEPTH + 1);
    localparam int WT_IDX_W = (WAITING_DEPTH > 1) ? $clog2(WAITING_DEPTH) : 1;
    localparam int WT_CNT_W = $clog2(WAITING_DEPTH + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // item opcodes
    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_EXEC  = 2'd1;
    localparam logic [1:0] OP_PURGE = 2'd2;

    // op classes
    localparam logic [2:0] CLS_PLAIN = 3'd0;
    localparam logic [2:0] CLS_LOAD  = 3'd1;
    localparam logic [2:0] CLS_STA   = 3'd2;
    localparam logic [2:0] CLS_STD   = 3'd3;
    localparam logic [2:0] CLS_BOTH  = 3'd4;

    // completion routes
    localparam logic [1:0] ROUTE_WB    = 2'd0;
    localparam logic [1:0] ROUTE_LOAD  = 2'd1;
    localparam logic [1:0] ROUTE_STORE = 2'd2;
    localparam logic [1:0] ROUTE_EXCP  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIPELINED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRP_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRP_A     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRP_B     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRP_C     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRP_D     = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] seq_id;
        logic [7:0]  latency;
        logic [7:0]  stall_cycles;
        logic [15:0] op_group;
        logic        already_flushed;
        logic [2:0]  op_class;
        logic        is_branch;
        logic        branch_taken;
        logic        mispredicted;
        logic        has_exception;
        logic [47:0] branch_target;
    } item_t;

    typedef struct packed {
        logic        done_res;
        logic [31:0] done_seq_id;
        logic [1:0]  done_route;
        logic        done_is_branch;
        logic        done_taken;
        logic        flush_request;
        logic [47:0] flush_address;
        logic [31:0] flush_after_seq;
        logic        input_held;
        logic [31:0] branches_executed;
        logic [31:0] mispredict_total;
        logic [31:0] accepted_total;
    } result_t;

    typedef struct packed {
        logic                                 pipelined_mode;
        logic [2:0]                           group_count;
        logic [NUM_BLOCKING_GROUPS-1:0][15:0] groups;
    } cfg_t;

    // per-op bookkeeping held in the queues
    typedef struct packed {
        logic        blocking;
        logic        exception;
        logic        mispred;
        logic        taken;
        logic        branch;
        logic [2:0]  cls;
        logic [31:0] seq;
    } info_t;

    // classified op handed from front to back
    typedef struct packed {
        logic [1:0]  opcode;
        info_t       info;
        logic [7:0]  lat;
        logic [7:0]  stl;
        logic        flushed;
        logic [47:0] target;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_PURGE,
        ST_RETIRE,
        ST_START,
        ST_FIN
    } st_t;

    function automatic logic [1:0] route_of(input info_t info);
        logic [1:0] r;
        r = ROUTE_WB;
        case (info.cls)
            CLS_LOAD:                    r = ROUTE_LOAD;
            CLS_STA, CLS_STD, CLS_BOTH:  r = ROUTE_STORE;
            default:                     r = ROUTE_WB;
        endcase
        if (info.exception)
            r = ROUTE_EXCP;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/eul_front.sv
// ----------------------------------------------------------------------------
// eul_front
// Takes an item, clamps its timing, matches its group against the blocking
// registers and parks it in a one-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module eul_front
    import eul_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    input  wire logic  take,
    output logic       op_valid,
    output op_t        op
);

    logic       valid_reg;
    op_t        op_reg;
    op_t        op_next;
    logic [2:0] n_active;
    logic       blk;
    logic       accept;

    assign accept = start && !valid_reg;

    // blocking group match
    always_comb
    begin
        n_active = (cfg.group_count > 3'(NUM_BLOCKING_GROUPS))
                   ? 3'(NUM_BLOCKING_GROUPS) : cfg.group_count;
        blk = 1'b0;
        for (int i = 0; i < NUM_BLOCKING_GROUPS; i++)
        begin
            if ((3'(i) < n_active) && (cfg.groups[i] == item.op_group))
                blk = 1'b1;
        end
    end

    // classified op
    always_comb
    begin
        op_next.opcode         = item.opcode;
        op_next.info.blocking  = blk;
        op_next.info.exception = item.has_exception;
        op_next.info.mispred   = item.mispredicted;
        op_next.info.taken     = item.branch_taken;
        op_next.info.branch    = item.is_branch;
        op_next.info.cls       = item.op_class;
        op_next.info.seq       = item.seq_id;
        op_next.lat            = (item.latency == 8'd0) ? 8'd1 : item.latency;
        op_next.stl            = (item.stall_cycles == 8'd0) ? 8'd1 : item.stall_cycles;
        op_next.flushed        = item.already_flushed;
        op_next.target         = item.branch_target;
    end

    // queue valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (accept)
            op_reg <= op_next;
    end

    assign op_valid = valid_reg;
    assign op       = op_reg;

endmodule

`default_nettype wire

// File: rtl/eul_back.sv
// ----------------------------------------------------------------------------
// eul_back
// Runs one classified op per pass: tick and issue, retire the completion
// queue head, start the next blocking op, or purge; then posts the result.
// ----------------------------------------------------------------------------
`default_nettype none

module eul_back
    import eul_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic op_valid,
    input  wire op_t  op,
    input  wire cfg_t cfg,
    output logic      take,
    output logic      result_valid,
    output result_t   result
);

    st_t state_reg, state_next;
    op_t cur_reg;

    logic [63:0] tick_reg, hold_reg;
    logic [IF_CNT_W-1:0] icnt_reg;
    logic [WT_CNT_W-1:0] wcnt_reg;
    logic        flush_reg;
    logic [47:0] last_target_reg;
    logic [31:0] last_flush_seq_reg;
    logic [31:0] branch_cnt_reg, mispred_cnt_reg, accepted_cnt_reg;
    logic        done_reg;
    logic [31:0] done_seq_reg;
    logic [1:0]  done_route_reg;
    logic        done_br_reg, done_tk_reg;
    logic        strobe_reg;
    result_t     result_reg;

    logic [63:0] if_ready_reg  [INFLIGHT_DEPTH];
    info_t       if_info_reg   [INFLIGHT_DEPTH];
    logic [47:0] if_target_reg [INFLIGHT_DEPTH];
    info_t       w_info_reg    [WAITING_DEPTH];
    logic [7:0]  w_lat_reg     [WAITING_DEPTH];
    logic [47:0] w_target_reg  [WAITING_DEPTH];

    // step control
    logic [63:0] t_now;
    logic        acc, full;
    logic        push_en, pop_en, wpush_en, wpop_en, purge_en;
    logic        hold_set, hold_clear, need_start;
    logic [63:0] push_ready, hold_val;
    info_t       push_info;
    info_t       wpush_info;
    logic [47:0] push_target;
    logic        cmp_en;
    info_t       cmp_info;
    logic [47:0] cmp_target;
    logic [1:0]  cmp_route;
    logic        cmp_br;
    logic [7:0]  s_cyc;

    // purge compaction
    logic [IF_CNT_W-1:0] pg_icnt;
    logic [WT_CNT_W-1:0] pg_wcnt;
    logic                if_keep [INFLIGHT_DEPTH];
    logic [IF_IDX_W-1:0] if_dest [INFLIGHT_DEPTH];
    logic                w_keep  [WAITING_DEPTH];
    logic [WT_IDX_W-1:0] w_dest  [WAITING_DEPTH];
    logic [63:0] pg_ready  [INFLIGHT_DEPTH];
    info_t       pg_info   [INFLIGHT_DEPTH];
    logic [47:0] pg_target [INFLIGHT_DEPTH];
    info_t       pg_winfo  [WAITING_DEPTH];
    logic [7:0]  pg_wlat   [WAITING_DEPTH];
    logic [47:0] pg_wtgt   [WAITING_DEPTH];
    logic        replace;
    logic [IF_IDX_W-1:0] tail_idx;

    assign full  = (icnt_reg >= IF_CNT_W'(INFLIGHT_DEPTH))
                || (wcnt_reg >= WT_CNT_W'(WAITING_DEPTH));
    assign t_now = tick_reg + 64'd1;
    assign take  = (state_reg == ST_IDLE) && op_valid;
    assign tail_idx = IF_IDX_W'(icnt_reg - IF_CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                    state_next = (op.opcode == OP_PURGE) ? ST_PURGE : ST_TICK;
            end
            ST_TICK:   state_next = ST_RETIRE;
            ST_RETIRE: state_next = need_start ? ST_START : ST_FIN;
            ST_PURGE:  state_next = need_start ? ST_START : ST_FIN;
            ST_START:  state_next = ST_FIN;
            ST_FIN:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // step outputs
    always_comb
    begin
        acc         = 1'b0;
        push_en     = 1'b0;
        pop_en      = 1'b0;
        wpush_en    = 1'b0;
        wpop_en     = 1'b0;
        purge_en    = 1'b0;
        hold_set    = 1'b0;
        hold_clear  = 1'b0;
        need_start  = 1'b0;
        s_cyc       = cfg.pipelined_mode ? cur_reg.stl : cur_reg.lat;
        hold_val    = t_now + 64'(s_cyc) - 64'd1;
        push_ready  = t_now + 64'(cur_reg.lat) - 64'd1;
        push_info   = cur_reg.info;
        wpush_info  = cur_reg.info;
        wpush_info.blocking = 1'b0;
        push_target = cur_reg.target;
        cmp_en      = 1'b0;
        cmp_info    = cur_reg.info;
        cmp_target  = cur_reg.target;
        unique case (state_reg)
            ST_TICK:
            begin
                acc = (cur_reg.opcode == OP_EXEC) && (hold_reg <= t_now)
                      && !full && !cur_reg.flushed;
                if (acc && cur_reg.info.blocking)
                begin
                    wpush_en = 1'b1;
                    push_en  = (wcnt_reg == '0);
                    push_info.blocking = 1'b1;
                end
                else if (acc && (cur_reg.lat == 8'd1) && (icnt_reg == '0))
                begin
                    cmp_en = 1'b1;
                end
                else if (acc)
                begin
                    push_en  = 1'b1;
                    hold_set = (s_cyc > 8'd1);
                end
            end
            ST_RETIRE:
            begin
                pop_en     = (icnt_reg != '0) && (if_ready_reg[0] <= tick_reg);
                wpop_en    = pop_en && if_info_reg[0].blocking && (wcnt_reg != '0);
                need_start = wpop_en && (wcnt_reg > WT_CNT_W'(1));
                cmp_en     = pop_en;
                cmp_info   = if_info_reg[0];
                cmp_target = if_target_reg[0];
            end
            ST_START:
            begin
                push_en     = (icnt_reg < IF_CNT_W'(INFLIGHT_DEPTH));
                push_ready  = tick_reg + 64'(w_lat_reg[0]) - 64'd1;
                push_info   = w_info_reg[0];
                push_info.blocking = 1'b1;
                push_target = w_target_reg[0];
            end
            ST_PURGE:
            begin
                purge_en   = (icnt_reg != '0);
                hold_clear = purge_en && (if_info_reg[tail_idx].seq > cur_reg.info.seq);
                need_start = purge_en && replace && (pg_wcnt != '0);
            end
            default:
            begin
            end
        endcase
        cmp_route = route_of(cmp_info);
        cmp_br    = ((cmp_route == ROUTE_WB) || (cmp_route == ROUTE_STORE)) && cmp_info.branch;
    end

    // purge compaction of both queues
    always_comb
    begin
        pg_icnt = '0;
        for (int i = 0; i < INFLIGHT_DEPTH; i++)
        begin
            if_keep[i] = (IF_CNT_W'(i) < icnt_reg)
                         && (if_info_reg[i].seq <= cur_reg.info.seq);
            if_dest[i] = IF_IDX_W'(pg_icnt);
            if (if_keep[i])
                pg_icnt = pg_icnt + IF_CNT_W'(1);
        end
        pg_wcnt = '0;
        for (int i = 0; i < WAITING_DEPTH; i++)
        begin
            w_keep[i] = (WT_CNT_W'(i) < wcnt_reg)
                        && (w_info_reg[i].seq <= cur_reg.info.seq);
            w_dest[i] = WT_IDX_W'(pg_wcnt);
            if (w_keep[i])
                pg_wcnt = pg_wcnt + WT_CNT_W'(1);
        end
        replace = (wcnt_reg != '0) && (w_info_reg[0].seq > cur_reg.info.seq);
        for (int n = 0; n < INFLIGHT_DEPTH; n++)
        begin
            pg_ready[n]  = if_ready_reg[n];
            pg_info[n]   = if_info_reg[n];
            pg_target[n] = if_target_reg[n];
            for (int i = 0; i < INFLIGHT_DEPTH; i++)
            begin
                if (if_keep[i] && (if_dest[i] == IF_IDX_W'(n)))
                begin
                    pg_ready[n]  = if_ready_reg[i];
                    pg_info[n]   = if_info_reg[i];
                    pg_target[n] = if_target_reg[i];
                end
            end
        end
        for (int n = 0; n < WAITING_DEPTH; n++)
        begin
            pg_winfo[n] = w_info_reg[n];
            pg_wlat[n]  = w_lat_reg[n];
            pg_wtgt[n]  = w_target_reg[n];
            for (int i = 0; i < WAITING_DEPTH; i++)
            begin
                if (w_keep[i] && (w_dest[i] == WT_IDX_W'(n)))
                begin
                    pg_winfo[n] = w_info_reg[i];
                    pg_wlat[n]  = w_lat_reg[i];
                    pg_wtgt[n]  = w_target_reg[i];
                end
            end
        end
    end

    // completion queue storage
    always_ff @(posedge clk)
    begin
        if (purge_en)
        begin
            if_ready_reg  <= pg_ready;
            if_info_reg   <= pg_info;
            if_target_reg <= pg_target;
        end
        else if (pop_en)
        begin
            for (int i = 0; i < INFLIGHT_DEPTH - 1; i++)
            begin
                if_ready_reg[i]  <= if_ready_reg[i+1];
                if_info_reg[i]   <= if_info_reg[i+1];
                if_target_reg[i] <= if_target_reg[i+1];
            end
        end
        else if (push_en)
        begin
            if_ready_reg[IF_IDX_W'(icnt_reg)]  <= push_ready;
            if_info_reg[IF_IDX_W'(icnt_reg)]   <= push_info;
            if_target_reg[IF_IDX_W'(icnt_reg)] <= push_target;
        end
    end

    // waiting queue storage
    always_ff @(posedge clk)
    begin
        if (purge_en)
        begin
            w_info_reg   <= pg_winfo;
            w_lat_reg    <= pg_wlat;
            w_target_reg <= pg_wtgt;
        end
        else if (wpop_en)
        begin
            for (int i = 0; i < WAITING_DEPTH - 1; i++)
            begin
                w_info_reg[i]   <= w_info_reg[i+1];
                w_lat_reg[i]    <= w_lat_reg[i+1];
                w_target_reg[i] <= w_target_reg[i+1];
            end
        end
        else if (wpush_en)
        begin
            w_info_reg[WT_IDX_W'(wcnt_reg)]   <= wpush_info;
            w_lat_reg[WT_IDX_W'(wcnt_reg)]    <= cur_reg.lat;
            w_target_reg[WT_IDX_W'(wcnt_reg)] <= cur_reg.target;
        end
    end

    // op latch
    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= op;
    end

    // control state, counters and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            tick_reg           <= '0;
            hold_reg           <= '0;
            icnt_reg           <= '0;
            wcnt_reg           <= '0;
            flush_reg          <= 1'b0;
            last_target_reg    <= '0;
            last_flush_seq_reg <= '0;
            branch_cnt_reg     <= '0;
            mispred_cnt_reg    <= '0;
            accepted_cnt_reg   <= '0;
            done_reg           <= 1'b0;
            done_seq_reg       <= '0;
            done_route_reg     <= '0;
            done_br_reg        <= 1'b0;
            done_tk_reg        <= 1'b0;
            strobe_reg         <= 1'b0;
            result_reg         <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == ST_FIN);

            if (state_reg == ST_TICK)
                tick_reg <= t_now;
            if (acc)
                accepted_cnt_reg <= accepted_cnt_reg + 32'd1;
            if (hold_set)
                hold_reg <= hold_val;
            else if (hold_clear)
                hold_reg <= tick_reg;

            // queue fill levels
            if (purge_en)
                icnt_reg <= pg_icnt;
            else if (pop_en)
                icnt_reg <= icnt_reg - IF_CNT_W'(1);
            else if (push_en)
                icnt_reg <= icnt_reg + IF_CNT_W'(1);
            if (purge_en)
                wcnt_reg <= pg_wcnt;
            else if (wpop_en)
                wcnt_reg <= wcnt_reg - WT_CNT_W'(1);
            else if (wpush_en)
                wcnt_reg <= wcnt_reg + WT_CNT_W'(1);

            // completion, or cleared per-tick result on a new tick or purge
            if (cmp_en)
            begin
                done_reg       <= 1'b1;
                done_seq_reg   <= cmp_info.seq;
                done_route_reg <= cmp_route;
                done_br_reg    <= cmp_br;
                done_tk_reg    <= cmp_br && cmp_info.taken;
                if (cmp_br)
                begin
                    last_target_reg <= cmp_target;
                    branch_cnt_reg  <= branch_cnt_reg + 32'd1;
                    if (cmp_info.mispred)
                    begin
                        last_flush_seq_reg <= cmp_info.seq;
                        mispred_cnt_reg    <= mispred_cnt_reg + 32'd1;
                    end
                end
            end
            else if ((state_reg == ST_TICK) || (state_reg == ST_PURGE))
            begin
                done_reg       <= 1'b0;
                done_seq_reg   <= '0;
                done_route_reg <= '0;
                done_br_reg    <= 1'b0;
                done_tk_reg    <= 1'b0;
            end

            // flush flag: raised by a mispredict, dropped on each new tick
            if (cmp_en && cmp_br && cmp_info.mispred)
                flush_reg <= 1'b1;
            else if (state_reg == ST_TICK)
                flush_reg <= 1'b0;

            // result transfer
            if (state_reg == ST_FIN)
            begin
                result_reg.done_res          <= done_reg;
                result_reg.done_seq_id       <= done_seq_reg;
                result_reg.done_route        <= done_route_reg;
                result_reg.done_is_branch    <= done_br_reg;
                result_reg.done_taken        <= done_tk_reg;
                result_reg.flush_request     <= flush_reg;
                result_reg.flush_address     <= last_target_reg;
                result_reg.flush_after_seq   <= last_flush_seq_reg;
                result_reg.input_held        <= (hold_reg > t_now) || full;
                result_reg.branches_executed <= branch_cnt_reg;
                result_reg.mispredict_total  <= mispred_cnt_reg;
                result_reg.accepted_total    <= accepted_cnt_reg;
            end
        end
    end

    assign result_valid = strobe_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// File: rtl/execute_unit_latency_scheduler_top.sv
// ----------------------------------------------------------------------------
// execute_unit_latency_scheduler_top
// In-order execute-stage latency tracker with blocking-group serialization.
// ----------------------------------------------------------------------------
// Each accepted item waits in a one-entry front queue until the back end is idle;
// the back end then steps a small sequencer through tick, retire and start
// phases (a purge through purge and start phases) over shared queue storage,
// entering the start phase only when a waiting blocking op is to be started.
// The front queue lets the next item be accepted while the current one is
// being worked on. Results come out as a one-cycle strobe that the receiver
// cannot hold off. Configuration is to be written by the user only while idle;
// the block itself does not enforce it.
`default_nettype none

module execute_unit_latency_scheduler_top
    import eul_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire item_t                 item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       result_valid,
    output result_t                    result
);

    cfg_t cfg_reg;
    logic op_valid;
    op_t  op;
    logic take;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pipelined_mode <= 1'b1;
            cfg_reg.group_count    <= '0;
            cfg_reg.groups         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PIPELINED: cfg_reg.pipelined_mode <= cfg_data[0];
                REG_GRP_COUNT: cfg_reg.group_count    <= cfg_data[2:0];
                REG_GRP_A:     cfg_reg.groups[0]      <= cfg_data;
                REG_GRP_B:     cfg_reg.groups[1]      <= cfg_data;
                REG_GRP_C:     cfg_reg.groups[2]      <= cfg_data;
                REG_GRP_D:     cfg_reg.groups[3]      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    eul_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .cfg      (cfg_reg),
        .take     (take),
        .op_valid (op_valid),
        .op       (op)
    );

    eul_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op           (op),
        .cfg          (cfg_reg),
        .take         (take),
        .result_valid (result_valid),
        .result       (result)
    );

    assign busy = op_valid;

    // an accepted transfer occupies the front queue
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not occupy the front queue");

    // result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // idle result carries zeroed completion fields
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.done_res) |->
        (result.done_seq_id == '0 && result.done_route == ROUTE_WB
         && !result.done_is_branch && !result.done_taken))
        else $error("idle result with completion fields set");

endmodule

`default_nettype wire
